@@ sv/sra_pkg.sv @@
// Shared types and constants for the scaled remainder accumulator.
`timescale 1ns / 1ps

package sra_pkg;

	localparam int FW    = 64;              // field width of factors and denominator
	localparam int PW    = 2 * FW;          // exact product / dividend width
	localparam int MW    = PW + FW;         // full scaled product width
	localparam int CNT_W = $clog2(FW);      // step counter width
	localparam int QW    = FW - 1;          // produced width

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FW - 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PROD_OVF = 2'd1,
		ST_SUM_OVF  = 2'd2,
		ST_QUO_BIG  = 2'd3
	} status_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL1 = 6'b000010,
		S_MUL2 = 6'b000100,
		S_CHK  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} seq_state_t;

	localparam int ADDR_W = 4;
	localparam logic [ADDR_W-1:0] ADDR_DENOM = ADDR_W'(0);

endpackage

@@ sv/scaled_remainder_accumulator_core.sv @@
// Top level: sequencer, carried remainder and result register of the accumulator.
`timescale 1ns / 1ps

// One item at a time: an item passes through numerator*service, the scaling by scale and
// the 128/64 division, on the single bit-serial multiplier used twice and the bit-serial
// divider. A failing item skips the division. A new item is accepted once the previous
// result sits in the output register, so the result may wait there while the next item
// is worked on. The denominator is written over the APB-style port (64-bit data,
// address 0); the user must write it only while the block is idle, which the block
// itself does not enforce. It resets to 1.

module scaled_remainder_accumulator_core
	import sra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [FW-1:0]     pwdata,
	output logic [FW-1:0]     prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [FW-1:0]     numerator,
	input  logic [FW-1:0]     service,
	input  logic [FW-1:0]     scale,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [QW-1:0]     produced,
	output logic [1:0]        status,
	output logic [FW-1:0]     new_remainder
);

	seq_state_t    state_q;
	logic [FW-1:0] denom;
	logic [FW-1:0] scale_q;
	logic [FW-1:0] rem_q;
	logic [PW-1:0] sum_q;
	logic          prod_ovf_q;
	logic          sum_ovf_q;
	status_t       stat_q;
	logic [QW-1:0] quo_q;
	logic          out_valid_q;
	status_t       out_status_q;
	logic [QW-1:0] out_produced_q;
	logic [FW-1:0] out_rem_q;

	logic          accept;
	logic          mul_start;
	logic [PW-1:0] mul_mcand;
	logic [FW-1:0] mul_mplier;
	logic          mul_done;
	logic [MW-1:0] mul_prod;
	logic          div_start;
	logic          div_done;
	logic [FW-1:0] div_quo;
	logic [FW-1:0] div_rem;
	logic [PW:0]   sum_full;
	logic          out_free;

	sra_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.denom   (denom)
	);

	assign pready = 1'b1;

	assign accept     = in_valid && state_q == S_IDLE;
	assign in_stall   = state_q != S_IDLE;
	assign mul_start  = accept || (state_q == S_MUL1 && mul_done);
	assign mul_mcand  = (state_q == S_IDLE) ? {{FW{1'b0}}, numerator} : mul_prod[PW-1:0];
	assign mul_mplier = (state_q == S_IDLE) ? service : scale_q;

	sra_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign sum_full  = {1'b0, mul_prod[PW-1:0]} + {{(FW+1){1'b0}}, rem_q};
	assign div_start = state_q == S_CHK && !prod_ovf_q && !sum_ovf_q
		&& denom != '0 && sum_q[PW-1:FW] < denom;

	sra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (sum_q[PW-1:FW]),
		.num_lo (sum_q[FW-1:0]),
		.den    (denom),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= div_start ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
						// commit the remainder only when the quotient fits
						if (!div_quo[FW-1]) begin
							rem_q <= div_rem;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scale_q <= scale;
		end
		if (state_q == S_MUL2 && mul_done) begin
			prod_ovf_q <= |mul_prod[MW-1:PW];
			sum_ovf_q  <= sum_full[PW];
			sum_q      <= sum_full[PW-1:0];
		end
		if (state_q == S_CHK) begin
			quo_q <= '0;
			if (prod_ovf_q) begin
				stat_q <= ST_PROD_OVF;
			end else if (sum_ovf_q) begin
				stat_q <= ST_SUM_OVF;
			end else begin
				stat_q <= ST_QUO_BIG;
			end
		end
		if (state_q == S_DIV && div_done) begin
			if (div_quo[FW-1]) begin
				stat_q <= ST_QUO_BIG;
				quo_q  <= '0;
			end else begin
				stat_q <= ST_OK;
				quo_q  <= div_quo[QW-1:0];
			end
		end
		if (state_q == S_FIN && out_free) begin
			out_status_q   <= stat_q;
			out_produced_q <= quo_q;
			out_rem_q      <= rem_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign produced      = out_produced_q;
	assign status        = out_status_q;
	assign new_remainder = out_rem_q;

endmodule

@@ sv/sra_regs.sv @@
// Configuration register file: APB-style access to the denominator.
`timescale 1ns / 1ps

module sra_regs
	import sra_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [FW-1:0]     pwdata,
	output logic [FW-1:0]     prdata,
	output logic [FW-1:0]     denom
);

	logic [FW-1:0] denom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denom_q <= FW'(1);
		end else if (psel && penable && pwrite && paddr == ADDR_DENOM) begin
			denom_q <= pwdata;
		end
	end

	assign denom  = denom_q;
	assign prdata = (paddr == ADDR_DENOM) ? denom_q : '0;

endmodule

@@ sv/sra_mul.sv @@
// Bit-serial shift-add multiplier: PW-bit multiplicand by FW-bit multiplier.
`timescale 1ns / 1ps

module sra_mul
	import sra_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] mcand,
	input  logic [FW-1:0] mplier,
	output logic          done,
	output logic [MW-1:0] prod
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    mcand_q;
	logic [FW-1:0]    mplier_q;
	logic [MW-1:0]    acc_q;
	logic [PW:0]      sum;

	// Add the multiplicand into the upper part when the current multiplier bit is set.
	assign sum = {1'b0, acc_q[MW-1:FW]} + (mplier_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= {sum, acc_q[FW-1:1]};
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ sv/sra_div.sv @@
// Bit-serial restoring divider: PW-bit dividend by FW-bit divisor, FW-bit quotient.
`timescale 1ns / 1ps

module sra_div
	import sra_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [FW-1:0] num_hi,
	input  logic [FW-1:0] num_lo,
	input  logic [FW-1:0] den,
	output logic          done,
	output logic [FW-1:0] quo,
	output logic [FW-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [FW-1:0]    rem_q;
	logic [FW-1:0]    lo_q;
	logic [FW:0]      shifted;
	logic [FW:0]      diff;
	logic             ge;

	// Shift in the next dividend bit; subtract when the partial remainder covers the divisor.
	assign shifted = {rem_q, lo_q[FW-1]};
	assign diff    = shifted - {1'b0, den};
	assign ge      = !diff[FW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			lo_q  <= num_lo;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FW-1:0] : shifted[FW-1:0];
			lo_q  <= {lo_q[FW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = lo_q;
	assign rem  = rem_q;

endmodule

@@ test/tb_scaled_remainder_accumulator_core.sv @@
// Self-checking testbench for the scaled remainder accumulator core.
`timescale 1ns / 1ps

module tb_scaled_remainder_accumulator_core;
	import sra_pkg::*;

	localparam logic [FW-1:0]     U64_ONES = '1;
	localparam logic [FW-1:0]     U64_MSB  = {1'b1, {(FW-1){1'b0}}};
	localparam logic [FW-1:0]     S64_MAX  = {1'b0, {(FW-1){1'b1}}};
	localparam logic [FW-1:0]     LO32_ONES = 64'h0000_0000_FFFF_FFFF;
	// factors of 2^64+1, used to build a product of exactly 2^128-1
	localparam logic [FW-1:0]     F6_SMALL = 64'd274177;
	localparam logic [FW-1:0]     F6_LARGE = 64'd67280421310721;
	localparam logic [FW-1:0]     HI32_F6  = 64'h0004_2F01_0004_2F01;
	localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(8);
	localparam int SW              = PW + 1;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int DRAIN_CYCLES    = 250;
	localparam int CYCLE_LIMIT     = 1_500_000;

	typedef struct {
		logic [QW-1:0] produced;
		status_t       status;
		logic [FW-1:0] remainder;
	} step_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [FW-1:0]     pwdata = '0;
	logic [FW-1:0]     prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [FW-1:0]     numerator = '0;
	logic [FW-1:0]     service = '0;
	logic [FW-1:0]     scale = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [QW-1:0]     produced;
	logic [1:0]        status;
	logic [FW-1:0]     new_remainder;

	logic [FW-1:0] model_denom;
	logic [FW-1:0] model_remainder;
	step_result_t  pending_results[$];
	step_result_t  oldest;
	int            src_idle_pct;
	int            sink_stall_pct;
	int            err_count;
	int            items_sent;
	int            denom_writes;
	int            status_seen[4];
	int            cycle_count;

	scaled_remainder_accumulator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.numerator     (numerator),
		.service       (service),
		.scale         (scale),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.produced      (produced),
		.status        (status),
		.new_remainder (new_remainder)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Expected outcome of one step; updates the carried remainder on success.
	function automatic step_result_t advance_accumulator(input logic [FW-1:0] num,
			input logic [FW-1:0] svc, input logic [FW-1:0] scl);
		logic [MW-1:0] prod;
		logic [SW-1:0] total;
		logic [PW-1:0] quo;
		step_result_t  r;
		prod = MW'(num) * MW'(svc) * MW'(scl);
		r.produced = '0;
		r.status = ST_OK;
		if (prod[MW-1:PW] != '0) begin
			r.status = ST_PROD_OVF;
		end else begin
			total = SW'(prod[PW-1:0]) + SW'(model_remainder);
			if (total[PW]) begin
				r.status = ST_SUM_OVF;
			end else if (model_denom == '0) begin
				r.status = ST_QUO_BIG;
			end else begin
				quo = total[PW-1:0] / PW'(model_denom);
				if (quo > PW'(S64_MAX)) begin
					r.status = ST_QUO_BIG;
				end else begin
					model_remainder = FW'(total[PW-1:0] % PW'(model_denom));
					r.produced = quo[QW-1:0];
				end
			end
		end
		r.remainder = model_remainder;
		return r;
	endfunction

	function automatic int bit_len(input logic [FW-1:0] v);
		int n;
		n = 0;
		for (int b = 0; b < FW; b++)
			if (v[b])
				n = b + 1;
		return n;
	endfunction

	// Random value of exactly w bits (top bit set), zero for w = 0.
	function automatic logic [FW-1:0] rand_width(input int w);
		logic [FW-1:0] v;
		v = {$urandom(), $urandom()};
		if (w <= 0)
			return '0;
		if (w < FW)
			v &= U64_ONES >> (FW - w);
		v[w-1] = 1'b1;
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: produced %0d status %0d new_remainder %h",
					produced, status, new_remainder);
				err_count++;
			end else begin
				oldest = pending_results.pop_front();
				status_seen[int'(oldest.status)]++;
				if (produced !== oldest.produced) begin
					$error("produced: expected %0d actual %0d", oldest.produced, produced);
					err_count++;
				end
				if (status !== oldest.status) begin
					$error("status: expected %0d actual %0d", oldest.status, status);
					err_count++;
				end
				if (new_remainder !== oldest.remainder) begin
					$error("new_remainder: expected %h actual %h",
						oldest.remainder, new_remainder);
					err_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic send_item(input logic [FW-1:0] num, input logic [FW-1:0] svc,
			input logic [FW-1:0] scl);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		numerator <= num;
		service <= svc;
		scale <= scl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(advance_accumulator(num, svc, scl));
		items_sent++;
	endtask

	// Drop valid and hold until every expected result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [FW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_DENOM)
			model_denom = data;
		denom_writes++;
		@(posedge clk);
	endtask

	task automatic check_denominator_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_DENOM;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== model_denom) begin
			$error("denominator: expected %h actual %h", model_denom, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_register_access();
		check_denominator_readback();
		// a write past the last register must leave the denominator alone
		reg_write(ADDR_SPARE, 64'd5);
		check_denominator_readback();
	endtask

	task automatic test_field_extremes();
		send_item('0, '0, '0);
		send_item(64'd1, 64'd1, 64'd1);
		send_item(S64_MAX, 64'd1, 64'd1);
		send_item(U64_ONES, 64'd1, 64'd1);
		send_item(U64_MSB, 64'd2, 64'd1);
		send_item('0, U64_ONES, U64_ONES);
		send_item(U64_ONES, U64_ONES, U64_ONES);
		send_item(U64_ONES, U64_ONES, 64'd1);
	endtask

	task automatic test_status_codes();
		wait_idle();
		reg_write(ADDR_DENOM, U64_ONES);
		check_denominator_readback();
		send_item(64'd5, 64'd3, 64'd1);
		send_item(U64_ONES, F6_SMALL, F6_LARGE);
		send_item(U64_ONES, U64_ONES, 64'd2);
		send_item(U64_ONES, U64_ONES, 64'd1);
		send_item(S64_MAX, U64_ONES, 64'd1);
	endtask

	task automatic test_zero_denominator();
		wait_idle();
		reg_write(ADDR_DENOM, '0);
		send_item(64'd1, 64'd1, 64'd1);
		send_item('0, '0, '0);
	endtask

	task automatic test_remainder_above_denominator();
		wait_idle();
		reg_write(ADDR_DENOM, U64_ONES);
		send_item(U64_MSB, 64'd1, 64'd1);
		// shrink the divisor below the carried remainder
		wait_idle();
		reg_write(ADDR_DENOM, 64'd3);
		send_item('0, '0, '0);
		send_item(64'd1, 64'd1, 64'd1);
	endtask

	task automatic send_random_item();
		logic [FW-1:0] f[3];
		logic [FW-1:0] t;
		int sel, budget, rest, w, j;
		sel = $urandom_range(0, 99);
		budget = -1;
		if (sel < 60) begin
			// product sized to keep the quotient within the signed maximum
			budget = $urandom_range(0, bit_len(model_denom) + 62);
		end else if (sel < 70) begin
			for (int k = 0; k < 3; k++)
				f[k] = {$urandom(), $urandom()};
		end else if (sel < 80) begin
			budget = $urandom_range(120, 134);
		end else if (sel < 90) begin
			budget = bit_len(model_denom) + $urandom_range(63, 68);
			if (budget > PW)
				budget = PW;
		end else if (sel < 95) begin
			// product of exactly 2^128-1: overflows once any remainder is carried
			if ($urandom_range(0, 1) == 0) begin
				f[0] = U64_ONES;
				f[1] = F6_SMALL;
			end else begin
				f[0] = LO32_ONES;
				f[1] = HI32_F6;
			end
			f[2] = F6_LARGE;
		end else begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 4))
					0: f[k] = '0;
					1: f[k] = 64'd1;
					2: f[k] = U64_ONES;
					3: f[k] = S64_MAX;
					default: f[k] = U64_MSB;
				endcase
			end
		end
		if (budget >= 0) begin
			rest = budget;
			for (int k = 0; k < 3; k++) begin
				w = (k == 2) ? rest : $urandom_range(0, rest < FW ? rest : FW);
				if (w > FW)
					w = FW;
				f[k] = rand_width(w);
				rest -= w;
			end
		end
		for (int k = 0; k < 3; k++) begin
			j = $urandom_range(0, 2);
			t = f[k];
			f[k] = f[j];
			f[j] = t;
		end
		send_item(f[0], f[1], f[2]);
	endtask

	task automatic test_random();
		logic [FW-1:0] denom;
		for (int p = 0; p < PHASES; p++) begin
			if (p < 2) begin
				src_idle_pct = 15;
				sink_stall_pct = 71;
			end else if (p < 4) begin
				src_idle_pct = 71;
				sink_stall_pct = 15;
			end else begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			case (p)
				0: denom = 64'd1;
				1: denom = U64_ONES;
				2: denom = 64'd3;
				3: denom = rand_width($urandom_range(1, FW));
				4: denom = U64_MSB;
				5: denom = FW'($urandom_range(2, 1000));
				default: denom = {$urandom(), $urandom()} | 64'd1;
			endcase
			wait_idle();
			reg_write(ADDR_DENOM, denom);
			check_denominator_readback();
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_random_item();
		end
	endtask

	initial begin
		model_denom = 64'd1;
		model_remainder = '0;
		src_idle_pct = 15;
		sink_stall_pct = 71;
		err_count = 0;
		items_sent = 0;
		denom_writes = 0;
		cycle_count = 0;
		for (int k = 0; k < 4; k++)
			status_seen[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_field_extremes();
		test_status_codes();
		test_zero_denominator();
		test_remainder_above_denominator();
		test_random();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d items across %0d register writes and three idling patterns.",
			items_sent, denom_writes);
		$display("Outcomes: ok %0d, product overflow %0d, sum overflow %0d, quotient too large %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/sra_pkg.sv
sv/sra_regs.sv
sv/sra_mul.sv
sv/sra_div.sv
sv/scaled_remainder_accumulator_core.sv
test/tb_scaled_remainder_accumulator_core.sv
